[rtl/cbf_pkg.sv]
// cbf_pkg: shared widths, Q1.16 constants and controller/datapath interface structs
// for the class belief fusion block. No dependencies.
package cbf_pkg;

    localparam int SCORE_W = 17;
    localparam int LABEL_W = 3;
    localparam int SRC_W   = 2;
    localparam int PROD_W  = 34;
    localparam int QUOT_W  = 17;
    localparam int BIT_W   = 5;

    localparam logic [SCORE_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [SCORE_W-1:0] CAP_98  = 17'd64225;

    localparam logic             OP_INIT  = 1'b0;
    localparam logic             OP_FUSE  = 1'b1;
    localparam logic [SRC_W-1:0] SRC_FULL = 2'd1;

    // commands from the controller, one strobe per datapath action
    typedef struct packed {
        logic capture;
        logic init_wr;
        logic rd_en;
        logic mul;
        logic acc;
        logic chk;
        logic div_load;
        logic div_step;
        logic q_wr;
        logic cap_fix;
    } t_dp_cmd;

    typedef struct packed {
        logic op_fuse;
        logic sum_zero;
    } t_dp_stat;

endpackage

[rtl/cbf_ctrl.sv]
// cbf_ctrl: sequencing state machine for the class belief fusion block.
// Depends on cbf_pkg for the command and status structs.
module cbf_ctrl #(
    parameter int NUM_CLASSES = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    output logic                                   o_done,
    output cbf_pkg::t_dp_cmd                       o_cmd,
    output logic [$clog2(NUM_CLASSES)-1:0]         o_addr,
    input  cbf_pkg::t_dp_stat                      i_stat
);

    localparam int IW = $clog2(NUM_CLASSES);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_INIT_WR  = 4'd2;
    localparam logic [3:0] S_SUM_RD   = 4'd3;
    localparam logic [3:0] S_SUM_MUL  = 4'd4;
    localparam logic [3:0] S_SUM_ACC  = 4'd5;
    localparam logic [3:0] S_CHECK    = 4'd6;
    localparam logic [3:0] S_Q_RD     = 4'd7;
    localparam logic [3:0] S_Q_MUL    = 4'd8;
    localparam logic [3:0] S_Q_LOAD   = 4'd9;
    localparam logic [3:0] S_Q_DIV    = 4'd10;
    localparam logic [3:0] S_Q_WR     = 4'd11;
    localparam logic [3:0] S_CAP      = 4'd12;
    localparam logic [3:0] S_RESULT   = 4'd13;

    logic [3:0]                 r_state, n_state;
    logic [IW-1:0]              r_idx, n_idx;
    logic [cbf_pkg::BIT_W-1:0]  r_bit, n_bit;
    logic                       w_last;

    assign w_last = (r_idx == IW'(NUM_CLASSES - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_bit   = r_bit;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_idx         = '0;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = i_stat.op_fuse ? S_SUM_RD : S_INIT_WR;
            end
            S_INIT_WR: begin
                o_cmd.init_wr = 1'b1;
                if (w_last) begin
                    n_state = S_RESULT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SUM_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SUM_MUL;
            end
            S_SUM_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.acc = 1'b1;
                if (w_last) begin
                    n_state = S_CHECK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SUM_RD;
                end
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                n_idx     = '0;
                n_state   = i_stat.sum_zero ? S_RESULT : S_Q_RD;
            end
            S_Q_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_Q_MUL;
            end
            S_Q_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_Q_LOAD;
            end
            S_Q_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_bit          = cbf_pkg::BIT_W'(cbf_pkg::QUOT_W - 1);
                n_state        = S_Q_DIV;
            end
            S_Q_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_Q_WR;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_Q_WR: begin
                o_cmd.q_wr = 1'b1;
                if (w_last) begin
                    n_state = S_CAP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_Q_RD;
                end
            end
            S_CAP: begin
                o_cmd.cap_fix = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bit   <= n_bit;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESULT);
    assign o_addr = r_idx;

endmodule

[rtl/cbf_dpath.sv]
// cbf_dpath: belief memory, multiplier, sum accumulator, restoring divider and argmax.
// Depends on cbf_pkg for constants and the command and status structs.
module cbf_dpath #(
    parameter int NUM_CLASSES = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cbf_pkg::t_dp_cmd                       i_cmd,
    input  logic [$clog2(NUM_CLASSES)-1:0]         i_addr,
    output cbf_pkg::t_dp_stat                      o_stat,
    input  logic                                   i_operation,
    input  logic [cbf_pkg::LABEL_W-1:0]            i_class_label,
    input  logic [cbf_pkg::SCORE_W-1:0]            i_detect_score,
    input  logic [cbf_pkg::SRC_W-1:0]              i_sensor_source,
    output logic [cbf_pkg::LABEL_W-1:0]            o_fused_label,
    output logic [cbf_pkg::SCORE_W-1:0]            o_fused_score,
    output logic                                   o_no_support
);

    localparam int IW    = $clog2(NUM_CLASSES);
    localparam int SW    = cbf_pkg::SCORE_W;
    localparam int QW    = cbf_pkg::QUOT_W;
    localparam int PW    = cbf_pkg::PROD_W;
    localparam int SUM_W = PW + IW;
    localparam int NUM_W = PW + QW;

    logic [SW-1:0]    r_mem [NUM_CLASSES];
    logic [SW-1:0]    r_rd_data;
    logic             r_loaded;

    logic             r_op;
    logic [cbf_pkg::LABEL_W-1:0] r_label;
    logic [SW-1:0]    r_base;
    logic [PW-1:0]    r_prod;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_rem;
    logic [QW-1:0]    r_nlow;
    logic [QW-1:0]    r_quot;
    logic [QW-1:0]    r_best_val;
    logic [IW-1:0]    r_best_idx;
    logic [cbf_pkg::LABEL_W-1:0] r_cur_label;
    logic [SW-1:0]    r_cur_score;
    logic             r_no_support;

    logic [SW-1:0]    w_init_s;
    logic [SW-1:0]    w_sat_s;
    logic [SW-1:0]    w_fuse_s;
    logic [SW-1:0]    w_s;
    logic [SW-1:0]    w_vec;
    logic [SW-1:0]    w_bel;
    logic [NUM_W-1:0] w_num;
    logic [SUM_W:0]   w_trial;
    logic [SUM_W:0]   w_diff;
    logic             w_ge;
    logic             w_we;
    logic [IW-1:0]    w_waddr;
    logic [SW-1:0]    w_wdata;

    // detection score conditioning
    assign w_init_s = (i_detect_score >= cbf_pkg::CAP_98) ? cbf_pkg::CAP_98 : i_detect_score;
    assign w_sat_s  = (i_detect_score > cbf_pkg::ONE_Q16) ? cbf_pkg::ONE_Q16 : i_detect_score;
    assign w_fuse_s = (i_sensor_source == cbf_pkg::SRC_FULL) ? w_sat_s : (w_sat_s >> 1);
    assign w_s      = (i_operation == cbf_pkg::OP_INIT) ? w_init_s : w_fuse_s;

    assign w_vec = (32'(i_addr) == 32'(r_label)) ? cbf_pkg::ONE_Q16 : r_base;
    assign w_bel = r_loaded ? r_rd_data : '0;

    // divider numerator: P * 2^16 + S / 2
    assign w_num   = NUM_W'({r_prod, 16'b0}) + NUM_W'(r_sum >> 1);
    assign w_trial = {r_rem, r_nlow[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_sum});
    assign w_diff  = w_trial - {1'b0, r_sum};

    assign w_we    = i_cmd.init_wr | i_cmd.q_wr | (i_cmd.cap_fix & r_best_val[QW-1]);
    assign w_waddr = i_cmd.cap_fix ? r_best_idx : i_addr;
    assign w_wdata = i_cmd.init_wr ? w_vec : (i_cmd.q_wr ? r_quot : cbf_pkg::CAP_98);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_label <= i_class_label;
            r_base  <= cbf_pkg::ONE_Q16 - w_s;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(w_bel) * PW'(w_vec);
        end
        if (i_cmd.capture) begin
            r_sum <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
        if (i_cmd.div_load) begin
            r_rem  <= SUM_W'(w_num[NUM_W-1:QW]);
            r_nlow <= w_num[QW-1:0];
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
            r_nlow <= {r_nlow[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], w_ge};
        end
        // lowest index wins a tie
        if (i_cmd.q_wr && ((i_addr == '0) || (r_quot > r_best_val))) begin
            r_best_val <= r_quot;
            r_best_idx <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded     <= 1'b0;
            r_cur_label  <= '0;
            r_cur_score  <= '0;
            r_no_support <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_loaded <= 1'b1;
            end
            if (i_cmd.capture) begin
                r_no_support <= 1'b0;
                if (i_operation == cbf_pkg::OP_INIT) begin
                    r_cur_label <= i_class_label;
                    r_cur_score <= w_init_s;
                end
            end
            if (i_cmd.chk) begin
                r_no_support <= (r_sum == '0);
            end
            if (i_cmd.cap_fix) begin
                r_cur_label <= cbf_pkg::LABEL_W'(r_best_idx);
                r_cur_score <= r_best_val[QW-1] ? cbf_pkg::CAP_98 : r_best_val;
            end
        end
    end

    assign o_stat.op_fuse  = (r_op == cbf_pkg::OP_FUSE);
    assign o_stat.sum_zero = (r_sum == '0);

    assign o_fused_label = r_cur_label;
    assign o_fused_score = r_cur_score;
    assign o_no_support  = r_no_support;

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.q_wr |-> (r_quot <= cbf_pkg::ONE_Q16))
        else $error("normalised belief above one");

    a_rem_below_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_sum))
        else $error("divider remainder not below divisor");

    a_cap_needs_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cap_fix |-> (r_sum != '0))
        else $error("belief rewritten after a zero product sum");

endmodule

[rtl/class_belief_fusion.sv]
// class_belief_fusion: top level of the Bayesian class-probability fusion block.
// Depends on cbf_pkg, cbf_ctrl and cbf_dpath.
//
// Usage:
// - Command channel: drive i_operation, i_class_label, i_detect_score and
//   i_sensor_source with start high; the beat is taken on the edge where busy
//   is low. Hold nothing afterwards: the fields are captured on that edge.
// - Result channel: o_valid is high for exactly one cycle and carries
//   o_fused_label, o_fused_score and o_no_support. The receiver cannot stall;
//   sample the beat on the edge that ends that cycle.
// - Sequencing: an init beat writes every class in turn, then gives the result.
//   A fuse beat first runs a sum pass (memory read, multiply and accumulate for
//   each class); when the product sum is zero it gives the result there.
//   Otherwise each class gets a memory read, the multiplier, the divider load,
//   the 17-step restoring divider (shared across all classes and run once per
//   class) and the write-back; a cap fix then comes before the result.
// - Throughput: one beat at a time; busy stays high until the result cycle
//   has passed.
// - Reset: synchronous, active low. Clear the belief (held as all zero until
//   the first init), the reported label and score, and return to idle.
module class_belief_fusion #(
    parameter int NUM_CLASSES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [cbf_pkg::LABEL_W-1:0]   i_class_label,
    input  logic [cbf_pkg::SCORE_W-1:0]   i_detect_score,
    input  logic [cbf_pkg::SRC_W-1:0]     i_sensor_source,
    output logic                          o_valid,
    output logic [cbf_pkg::LABEL_W-1:0]   o_fused_label,
    output logic [cbf_pkg::SCORE_W-1:0]   o_fused_score,
    output logic                          o_no_support
);

    localparam int IW = $clog2(NUM_CLASSES);

    cbf_pkg::t_dp_cmd  w_cmd;
    cbf_pkg::t_dp_stat w_stat;
    logic [IW-1:0]     w_addr;

    // sequencer: walks init writes, the sum pass and the per-class divide
    cbf_ctrl #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_valid),
        .o_cmd   (w_cmd),
        .o_addr  (w_addr),
        .i_stat  (w_stat)
    );

    // belief store and arithmetic; the reported fields are its registers
    cbf_dpath #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_addr          (w_addr),
        .o_stat          (w_stat),
        .i_operation     (i_operation),
        .i_class_label   (i_class_label),
        .i_detect_score  (i_detect_score),
        .i_sensor_source (i_sensor_source),
        .o_fused_label   (o_fused_label),
        .o_fused_score   (o_fused_score),
        .o_no_support    (o_no_support)
    );

endmodule

[dv/tb_class_belief_fusion.sv]
// tb_class_belief_fusion: self-checking testbench for the class belief fusion block.
// Depends on cbf_pkg and class_belief_fusion; holds its own Q1.16 belief predictor.
module tb_class_belief_fusion;
    import cbf_pkg::*;

    localparam int NCLS           = 8;
    localparam int WATCHDOG_LIMIT = 4000;  // worst quiet stretch is a busy fuse beat plus the longest sender gap
    localparam int DRAIN_CYCLES   = 250;   // a little more than one fuse beat
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [SCORE_W-1:0] score;
        logic               no_support;
    } fused_t;

    // clock, reset and stimulus; every input is known from time zero
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               start           = 1'b0;
    logic               i_operation     = OP_INIT;
    logic [LABEL_W-1:0] i_class_label   = '0;
    logic [SCORE_W-1:0] i_detect_score  = '0;
    logic [SRC_W-1:0]   i_sensor_source = '0;
    logic               busy;
    logic               o_valid;
    logic [LABEL_W-1:0] o_fused_label;
    logic [SCORE_W-1:0] o_fused_score;
    logic               o_no_support;

    // predictor state: a copy of the belief vector and the reported class
    logic [SCORE_W-1:0] belief_q16 [NCLS];
    logic [LABEL_W-1:0] track_label;
    logic [SCORE_W-1:0] track_score;
    fused_t             fused_expect_q [$];

    int sender_idle_pct = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;
    int n_init          = 0;
    int n_fuse          = 0;
    int n_results       = 0;
    int n_no_support    = 0;
    int n_capped        = 0;
    fused_t got_r;
    fused_t want_r;

    always #2 i_clk = ~i_clk;

    class_belief_fusion #(
        .NUM_CLASSES(NCLS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_class_label   (i_class_label),
        .i_detect_score  (i_detect_score),
        .i_sensor_source (i_sensor_source),
        .o_valid         (o_valid),
        .o_fused_label   (o_fused_label),
        .o_fused_score   (o_fused_score),
        .o_no_support    (o_no_support)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_belief();
        for (int i = 0; i < NCLS; i++)
            belief_q16[i] = '0;
        track_label = '0;
        track_score = '0;
    endtask

    // Advance the predicted belief by one accepted beat and queue the result.
    task automatic predict_fused_class(input logic op, input logic [LABEL_W-1:0] lbl,
                                       input logic [SCORE_W-1:0] score,
                                       input logic [SRC_W-1:0] src);
        logic [SCORE_W-1:0] s;
        logic [SCORE_W-1:0] vec [NCLS];
        logic [63:0]        prod [NCLS];
        logic [63:0]        total;
        logic [63:0]        q;
        logic [63:0]        best_q;
        int                 best;
        logic               flag;
        flag = 1'b0;
        if (op == OP_INIT) begin
            // cap the detection at 0.98, then the labelled class is certain
            s = (score >= CAP_98) ? CAP_98 : score;
            for (int i = 0; i < NCLS; i++)
                belief_q16[i] = ONE_Q16 - s;
            if (int'(lbl) < NCLS)
                belief_q16[lbl] = ONE_Q16;
            track_label = lbl;
            track_score = s;
        end else begin
            // saturate to 1.0, halve for any source but the full-weight one
            s = (score > ONE_Q16) ? ONE_Q16 : score;
            if (src != SRC_FULL)
                s = s >> 1;
            for (int i = 0; i < NCLS; i++)
                vec[i] = ONE_Q16 - s;
            if (int'(lbl) < NCLS)
                vec[lbl] = ONE_Q16;
            total = '0;
            for (int i = 0; i < NCLS; i++) begin
                prod[i] = 64'(belief_q16[i]) * 64'(vec[i]);
                total   = total + prod[i];
            end
            if (total == 0) begin
                // no support anywhere: keep the belief and report it again
                flag = 1'b1;
            end else begin
                best   = 0;
                best_q = '0;
                for (int i = 0; i < NCLS; i++) begin
                    q = (prod[i] * 64'(ONE_Q16) + total / 2) / total;
                    belief_q16[i] = q[SCORE_W-1:0];
                    if (i == 0 || q > best_q) begin
                        best_q = q;
                        best   = i;
                    end
                end
                if (best_q >= 64'(ONE_Q16)) begin
                    best_q           = 64'(CAP_98);
                    belief_q16[best] = CAP_98;
                    n_capped++;
                end
                track_label = LABEL_W'(best);
                track_score = best_q[SCORE_W-1:0];
            end
        end
        fused_expect_q.push_back('{label: track_label, score: track_score, no_support: flag});
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Send one command beat; return at the edge that took it, with start still high.
    task automatic send_beat(input logic op, input logic [LABEL_W-1:0] lbl,
                             input logic [SCORE_W-1:0] score,
                             input logic [SRC_W-1:0] src);
        int gap;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            // mostly short gaps, some long enough to land anywhere in a fuse
            gap = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 240);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_operation     <= op;
        i_class_label   <= lbl;
        i_detect_score  <= score;
        i_sensor_source <= src;
        do
            @(posedge i_clk);
        while (busy);
        if (op == OP_INIT)
            n_init++;
        else
            n_fuse++;
        predict_fused_class(op, lbl, score, src);
    endtask

    // Drop start and hold off until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (fused_expect_q.size() != 0);
    endtask

    function automatic logic [SCORE_W-1:0] random_score();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return SCORE_W'($urandom_range(64220, 64230));
            3:       return SCORE_W'($urandom_range(65537, 131071));
            4:       return SCORE_W'($urandom_range(255));
            default: return SCORE_W'($urandom_range(65536));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string why, input fused_t want, input fused_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH %0s: expected label %0d score %0d flag %0d, got label %0d score %0d flag %0d",
                     why, want.label, want.score, want.no_support,
                     got.label, got.score, got.no_support);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_results++;
            got_r = '{label: o_fused_label, score: o_fused_score, no_support: o_no_support};
            if (fused_expect_q.size() == 0) begin
                log_mismatch("result with none pending", '0, got_r);
            end else begin
                want_r = fused_expect_q.pop_front();
                if (want_r.no_support)
                    n_no_support++;
                if (got_r.label !== want_r.label || got_r.score !== want_r.score
                        || got_r.no_support !== want_r.no_support)
                    log_mismatch("field differs", want_r, got_r);
            end
        end
    end

    // Watchdog: count edges at which neither a command nor a result beat moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles, %0d results pending",
                         quiet_cycles, fused_expect_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // A fuse before any init meets an all-zero belief: no support, label and score zero.
    task automatic test_fuse_before_init();
        send_beat(OP_FUSE, 3'd5, ONE_Q16, SRC_FULL);
        send_beat(OP_FUSE, 3'd0, 17'd0, 2'd3);
    endtask

    // Init with the score at zero, at and around the 0.98 cap, at 1.0 and above.
    task automatic test_init_extremes();
        send_beat(OP_INIT, 3'd0, 17'd0, 2'd0);
        send_beat(OP_INIT, 3'd7, 17'h1FFFF, 2'd2);
        send_beat(OP_INIT, 3'd3, ONE_Q16, SRC_FULL);
        send_beat(OP_INIT, 3'd2, CAP_98, 2'd3);
        send_beat(OP_INIT, 3'd6, CAP_98 - 17'd1, 2'd0);
    endtask

    // Uniform belief against a flat detection: equal maxima, lowest index wins.
    task automatic test_tie_break();
        send_beat(OP_INIT, 3'd4, 17'd0, SRC_FULL);
        send_beat(OP_FUSE, 3'd6, 17'd0, 2'd2);
        send_beat(OP_FUSE, 3'd5, 17'd1, 2'd0);
    endtask

    // Certain detection collapses the belief onto one class (capped at 0.98);
    // a certain detection of another class then finds no support.
    task automatic test_collapse_and_no_support();
        send_beat(OP_INIT, 3'd1, 17'd30000, 2'd0);
        send_beat(OP_FUSE, 3'd1, ONE_Q16, SRC_FULL);
        send_beat(OP_FUSE, 3'd6, ONE_Q16, SRC_FULL);
        send_beat(OP_FUSE, 3'd6, 17'h1FFFF, SRC_FULL);
        send_beat(OP_FUSE, 3'd1, 17'd100, 2'd0);
    endtask

    // Every source value, with saturation on the half-weight path.
    task automatic test_sources();
        send_beat(OP_INIT, 3'd2, 17'd50000, 2'd1);
        for (int s = 0; s < 4; s++)
            send_beat(OP_FUSE, 3'd2, 17'd40000, SRC_W'(s));
        send_beat(OP_FUSE, 3'd5, 17'h1FFFF, 2'd2);
        send_beat(OP_FUSE, 3'd7, 17'h15555, 2'd3);
    endtask

    // Tracks: an init then a run of fuses, mostly on the same class, with some
    // noise beats and some runs that skip the init and carry on the old belief.
    task automatic test_random_tracks(input int n_items, input int idle_pct);
        int                 sent;
        int                 run_len;
        logic [LABEL_W-1:0] track_cls;
        logic [LABEL_W-1:0] lbl;
        sender_idle_pct = idle_pct;
        sent            = 0;
        track_cls       = LABEL_W'($urandom_range(NCLS - 1));
        while (sent < n_items) begin
            if ($urandom_range(9) != 0) begin
                track_cls = LABEL_W'($urandom_range(NCLS - 1));
                send_beat(OP_INIT, track_cls, random_score(), SRC_W'($urandom_range(3)));
                sent++;
            end
            run_len = $urandom_range(1, 12);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                lbl = ($urandom_range(9) < 6) ? track_cls : LABEL_W'($urandom_range(NCLS - 1));
                send_beat(OP_FUSE, lbl, random_score(), SRC_W'($urandom_range(3)));
                sent++;
            end
            // now and then let the block run dry before the next track
            if ($urandom_range(39) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_belief();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 18;
        test_fuse_before_init();
        test_init_extremes();
        drain_results();
        test_tie_break();
        test_collapse_and_no_support();
        drain_results();
        test_sources();

        test_random_tracks(567, 18);
        test_random_tracks(567, 64);
        test_random_tracks(566, 0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d init and %0d fuse beats, %0d results checked",
                 n_init, n_fuse, n_results);
        $display("of which %0d had no support and %0d hit the 0.98 cap; %0d mismatches",
                 n_no_support, n_capped, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/cbf_pkg.sv
rtl/cbf_ctrl.sv
rtl/cbf_dpath.sv
rtl/class_belief_fusion.sv
dv/tb_class_belief_fusion.sv
